// ----- src/scas_pkg.sv -----
// shared types, constants and register codes for the sensor channel average and scale block
`timescale 1ns / 1ps
`default_nettype none
package scas_pkg;

  localparam int unsigned CodeW = 12;
  localparam int unsigned ChanW = 2;
  localparam int unsigned NumOutCh = 4;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned RingDepthDefault = 256;
  localparam int unsigned ChannelCountDefault = 4;

  localparam logic OpSample = 1'b0;
  localparam logic OpRead = 1'b1;

  localparam logic [CfgIdxW-1:0] RegPressureZero = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPressureGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPressureLimit = 3'd2;
  localparam logic [CfgIdxW-1:0] RegThrottleZero = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThrottleGain = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLambdaGain = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLambdaOffset = 3'd6;

  localparam logic [CodeW-1:0] PressureZeroReset = 12'd0;
  localparam logic [15:0] PressureGainReset = 16'd256;
  localparam logic [CodeW-1:0] PressureLimitReset = 12'd1050;
  localparam logic [CodeW-1:0] ThrottleZeroReset = 12'd0;
  localparam logic [15:0] ThrottleGainReset = 16'd62;
  localparam logic [15:0] LambdaGainReset = 16'd4191;
  localparam logic [15:0] LambdaOffsetReset = 16'd2048;

  localparam logic [9:0] ThrottleFull = 10'd1000;

  typedef logic [CodeW-1:0] code_t;
  typedef code_t [NumOutCh-1:0] avg_vec_t;

  typedef struct packed {
    logic [CodeW-1:0] pressure_zero;
    logic [15:0] pressure_gain;
    logic [CodeW-1:0] pressure_limit;
    logic [CodeW-1:0] throttle_zero;
    logic [15:0] throttle_gain;
    logic [15:0] lambda_gain;
    logic [15:0] lambda_offset;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic [ChanW-1:0] channel;
    code_t code;
  } sample_req_t;

endpackage
`default_nettype wire

// ----- src/scas_ring.sv -----
// per-channel sample ring memory with write positions and fill flags
`timescale 1ns / 1ps
`default_nettype none
module scas_ring #(
  parameter int unsigned RING_DEPTH = scas_pkg::RingDepthDefault,
  parameter int unsigned CHANNEL_COUNT = scas_pkg::ChannelCountDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire scas_pkg::sample_req_t req_i,
  output scas_pkg::code_t           old_code_o
);

  localparam int unsigned MemDepth = CHANNEL_COUNT * RING_DEPTH;
  localparam int unsigned AddrW = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int unsigned PosW = $clog2(RING_DEPTH);
  localparam int unsigned ChanIdxW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  scas_pkg::code_t mem [MemDepth];
  scas_pkg::code_t rdata_q;
  logic [PosW-1:0] pos_q [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] filled_q;
  logic old_ok_q;

  logic [ChanIdxW-1:0] ch_idx;
  logic [PosW-1:0] pos_cur;
  logic [AddrW-1:0] addr;
  logic wrap;

  assign ch_idx = ChanIdxW'(req_i.channel);
  assign pos_cur = pos_q[ch_idx];
  assign addr = AddrW'(ch_idx) * AddrW'(RING_DEPTH) + AddrW'(pos_cur);
  assign wrap = (pos_cur == PosW'(RING_DEPTH - 1));

  // read-first port: returns the oldest code while the new one replaces it
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      mem[addr] <= req_i.code;
      rdata_q <= mem[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNEL_COUNT); i++) begin
        pos_q[i] <= '0;
      end
      filled_q <= '0;
      old_ok_q <= 1'b0;
    end else if (req_i.valid) begin
      pos_q[ch_idx] <= wrap ? '0 : pos_cur + PosW'(1);
      if (wrap) begin
        filled_q[ch_idx] <= 1'b1;
      end
      old_ok_q <= filled_q[ch_idx];
    end
  end

  // entries not yet written since reset read as zero
  assign old_code_o = old_ok_q ? rdata_q : '0;

endmodule
`default_nettype wire

// ----- src/scas_accum.sv -----
// running sums per channel and their averages by reciprocal multiply
`timescale 1ns / 1ps
`default_nettype none
module scas_accum #(
  parameter int unsigned RING_DEPTH = scas_pkg::RingDepthDefault,
  parameter int unsigned CHANNEL_COUNT = scas_pkg::ChannelCountDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire scas_pkg::sample_req_t upd_i,
  input  wire scas_pkg::code_t       old_code_i,
  output scas_pkg::avg_vec_t         avg_o
);

  localparam int unsigned CodeW = scas_pkg::CodeW;
  localparam int unsigned LogD = $clog2(RING_DEPTH);
  localparam int unsigned SumW = CodeW + LogD;
  localparam int unsigned RecipShift = SumW + LogD;
  localparam int unsigned RecipW = SumW + 1;
  localparam int unsigned ProdW = SumW + RecipW;
  localparam longint unsigned RecipMul =
    ((64'd1 << RecipShift) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
  localparam int unsigned ChanIdxW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

  logic [SumW-1:0] sum_q [CHANNEL_COUNT];
  logic [ChanIdxW-1:0] ch_idx;

  assign ch_idx = ChanIdxW'(upd_i.channel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(CHANNEL_COUNT); i++) begin
        sum_q[i] <= '0;
      end
    end else if (upd_i.valid) begin
      sum_q[ch_idx] <= sum_q[ch_idx] - SumW'(old_code_i) + SumW'(upd_i.code);
    end
  end

  for (genvar k = 0; k < int'(scas_pkg::NumOutCh); k++) begin : g_avg
    if (k < int'(CHANNEL_COUNT)) begin : g_built
      logic [ProdW-1:0] prod;
      assign prod = ProdW'(sum_q[k]) * ProdW'(RecipW'(RecipMul));
      assign avg_o[k] = prod[RecipShift +: CodeW];
    end else begin : g_absent
      assign avg_o[k] = '0;
    end
  end

endmodule
`default_nettype wire

// ----- src/scas_scale.sv -----
// scaling, clamping and output register stages for read requests
`timescale 1ns / 1ps
`default_nettype none
module scas_scale (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire scas_pkg::avg_vec_t avg_i,
  input  wire scas_pkg::cfg_t     cfg_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [11:0]             pressure_tenth_kpa_o,
  output logic [9:0]              throttle_tenth_pct_o,
  output logic [15:0]             lambda_q12_o,
  output logic [11:0]             intake_temp_code_o,
  output logic [11:0]             coolant_temp_code_o
);

  logic v2_q, v3_q, out_v_q;
  logic ready2, ready3, ready_out;

  scas_pkg::avg_vec_t avg2_q;

  logic [27:0] p_prod_q, t_prod_q, l_prod_q;
  scas_pkg::code_t intake3_q, coolant3_q;

  logic [11:0] p_diff, t_diff;
  logic [27:0] p_prod_d, t_prod_d, l_prod_d;

  logic [19:0] p_shift, t_shift;
  logic [16:0] l_sum;
  logic [11:0] p_d;
  logic [9:0] t_d;
  logic [15:0] l_d;

  logic [11:0] pressure_q, intake_q, coolant_q;
  logic [9:0] throttle_q;
  logic [15:0] lambda_q;

  assign ready_out = !out_v_q || !out_stall_i;
  assign ready3 = !v3_q || ready_out;
  assign ready2 = !v2_q || ready3;
  assign in_ready_o = ready2;

  always_comb begin
    p_diff = (avg2_q[0] > cfg_i.pressure_zero) ? avg2_q[0] - cfg_i.pressure_zero : '0;
    t_diff = (avg2_q[1] > cfg_i.throttle_zero) ? avg2_q[1] - cfg_i.throttle_zero : '0;
    p_prod_d = 28'(p_diff) * 28'(cfg_i.pressure_gain);
    t_prod_d = 28'(t_diff) * 28'(cfg_i.throttle_gain);
    l_prod_d = 28'(avg2_q[0]) * 28'(cfg_i.lambda_gain);
  end

  always_comb begin
    p_shift = p_prod_q[27:8];
    t_shift = t_prod_q[27:8];
    l_sum = 17'(cfg_i.lambda_offset) + 17'(l_prod_q[27:12]);
    p_d = (p_shift > 20'(cfg_i.pressure_limit)) ? cfg_i.pressure_limit : p_shift[11:0];
    t_d = (t_shift > 20'(scas_pkg::ThrottleFull)) ? scas_pkg::ThrottleFull : t_shift[9:0];
    l_d = l_sum[16] ? 16'hFFFF : l_sum[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (ready2) begin
        v2_q <= in_valid_i;
      end
      if (ready3) begin
        v3_q <= v2_q;
      end
      if (ready_out) begin
        out_v_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && in_valid_i) begin
      avg2_q <= avg_i;
    end
    if (ready3 && v2_q) begin
      p_prod_q <= p_prod_d;
      t_prod_q <= t_prod_d;
      l_prod_q <= l_prod_d;
      intake3_q <= avg2_q[2];
      coolant3_q <= avg2_q[3];
    end
    if (ready_out && v3_q) begin
      pressure_q <= p_d;
      throttle_q <= t_d;
      lambda_q <= l_d;
      intake_q <= intake3_q;
      coolant_q <= coolant3_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign pressure_tenth_kpa_o = pressure_q;
  assign throttle_tenth_pct_o = throttle_q;
  assign lambda_q12_o = lambda_q;
  assign intake_temp_code_o = intake_q;
  assign coolant_temp_code_o = coolant_q;

endmodule
`default_nettype wire

// ----- src/sensor_channel_average_scale_core.sv -----
// top level of the sensor channel average and scale block
`timescale 1ns / 1ps
`default_nettype none
// Takes one request per cycle, sample or read, with no bubbles while the input is not
// stalled. A sample request does a read-modify-write of its channel's ring entry in a
// single read-first memory port and updates the channel's running sum in the following
// cycle; it gives no result and never stalls the input. A read request forms every
// channel's average from the running sums and leaves the block through the first
// stage, a reciprocal-multiply, a scaling-multiply and a clamp/output stage. The input
// stalls only while a read waits behind a full result pipeline. The ring needs no
// clearing pass after reset: per-channel fill flags make unwritten entries read as
// zero, so requests are taken as soon as reset is released.
module sensor_channel_average_scale_core #(
  parameter int unsigned RING_DEPTH = scas_pkg::RingDepthDefault,
  parameter int unsigned CHANNEL_COUNT = scas_pkg::ChannelCountDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          op_i,
  input  wire logic [1:0]                    channel_i,
  input  wire logic [11:0]                   sample_code_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [11:0]                        pressure_tenth_kpa_o,
  output logic [9:0]                         throttle_tenth_pct_o,
  output logic [15:0]                        lambda_q12_o,
  output logic [11:0]                        intake_temp_code_o,
  output logic [11:0]                        coolant_temp_code_o,
  input  wire logic                          cfg_write_en_i,
  input  wire logic [scas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [scas_pkg::CfgDataW-1:0] cfg_data_i
);

  scas_pkg::cfg_t cfg_q;

  logic s1_v_q, s1_read_q, s1_built_q;
  logic [1:0] s1_ch_q;
  scas_pkg::code_t s1_code_q;

  logic s1_ready, accept, built, scale_ready;
  scas_pkg::sample_req_t ring_req, acc_upd;
  scas_pkg::code_t old_code;
  scas_pkg::avg_vec_t avg;

  assign built = int'(channel_i) < int'(CHANNEL_COUNT);
  assign s1_ready = !s1_v_q || !s1_read_q || scale_ready;
  assign accept = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pressure_zero <= scas_pkg::PressureZeroReset;
      cfg_q.pressure_gain <= scas_pkg::PressureGainReset;
      cfg_q.pressure_limit <= scas_pkg::PressureLimitReset;
      cfg_q.throttle_zero <= scas_pkg::ThrottleZeroReset;
      cfg_q.throttle_gain <= scas_pkg::ThrottleGainReset;
      cfg_q.lambda_gain <= scas_pkg::LambdaGainReset;
      cfg_q.lambda_offset <= scas_pkg::LambdaOffsetReset;
    end else if (cfg_write_en_i) begin
      unique case (cfg_index_i)
        scas_pkg::RegPressureZero:  cfg_q.pressure_zero <= cfg_data_i[11:0];
        scas_pkg::RegPressureGain:  cfg_q.pressure_gain <= cfg_data_i;
        scas_pkg::RegPressureLimit: cfg_q.pressure_limit <= cfg_data_i[11:0];
        scas_pkg::RegThrottleZero:  cfg_q.throttle_zero <= cfg_data_i[11:0];
        scas_pkg::RegThrottleGain:  cfg_q.throttle_gain <= cfg_data_i;
        scas_pkg::RegLambdaGain:    cfg_q.lambda_gain <= cfg_data_i;
        scas_pkg::RegLambdaOffset:  cfg_q.lambda_offset <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s1_read_q <= 1'b0;
      s1_built_q <= 1'b0;
    end else if (s1_ready) begin
      s1_v_q <= accept;
      s1_read_q <= (op_i == scas_pkg::OpRead);
      s1_built_q <= built;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ch_q <= channel_i;
      s1_code_q <= sample_code_i;
    end
  end

  assign ring_req.valid = accept && (op_i == scas_pkg::OpSample) && built;
  assign ring_req.channel = channel_i;
  assign ring_req.code = sample_code_i;

  assign acc_upd.valid = s1_v_q && !s1_read_q && s1_built_q;
  assign acc_upd.channel = s1_ch_q;
  assign acc_upd.code = s1_code_q;

  scas_ring #(
    .RING_DEPTH   (RING_DEPTH),
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ring_req),
    .old_code_o(old_code)
  );

  scas_accum #(
    .RING_DEPTH   (RING_DEPTH),
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .upd_i     (acc_upd),
    .old_code_i(old_code),
    .avg_o     (avg)
  );

  scas_scale u_scale (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (s1_v_q && s1_read_q),
    .in_ready_o          (scale_ready),
    .avg_i               (avg),
    .cfg_i               (cfg_q),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .pressure_tenth_kpa_o(pressure_tenth_kpa_o),
    .throttle_tenth_pct_o(throttle_tenth_pct_o),
    .lambda_q12_o        (lambda_q12_o),
    .intake_temp_code_o  (intake_temp_code_o),
    .coolant_temp_code_o (coolant_temp_code_o)
  );

  a_sample_never_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_read_q) |-> !in_stall_o)
    else $error("sample request in first stage blocked the input");

  a_stall_only_for_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && s1_read_q && !scale_ready))
    else $error("input stalled without a waiting read");

  a_read_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_i == scas_pkg::OpRead)) |=> (s1_v_q && s1_read_q))
    else $error("accepted read request lost before first stage");

endmodule
`default_nettype wire

// ----- tb/scas_readings_checker.sv -----
// checker: predicts the converted readings of the sensor block and compares each result
`timescale 1ns / 1ps
module scas_readings_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          op_i,
  input  logic [1:0]                    channel_i,
  input  logic [11:0]                   sample_code_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [11:0]                   pressure_tenth_kpa_i,
  input  logic [9:0]                    throttle_tenth_pct_i,
  input  logic [15:0]                   lambda_q12_i,
  input  logic [11:0]                   intake_temp_code_i,
  input  logic [11:0]                   coolant_temp_code_i,
  input  logic                          cfg_write_en_i,
  input  logic [scas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [scas_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                   outstanding_o,
  output int unsigned                   fail_count_o
);
  import scas_pkg::*;

  localparam int unsigned RING_DEPTH = RingDepthDefault;
  localparam int unsigned CHANNEL_COUNT = ChannelCountDefault;
  localparam int unsigned PosW = $clog2(RING_DEPTH);

  typedef struct packed {
    logic [11:0] pressure_tenth_kpa;
    logic [9:0]  throttle_tenth_pct;
    logic [15:0] lambda_q12;
    logic [11:0] intake_temp_code;
    logic [11:0] coolant_temp_code;
  } readings_t;

  cfg_t          settings;
  code_t         ring_model [CHANNEL_COUNT][RING_DEPTH];
  logic [19:0]   channel_sum [CHANNEL_COUNT];
  logic [PosW-1:0] write_pos [CHANNEL_COUNT];
  readings_t     expected_readings [$];
  readings_t     want;
  int unsigned   mismatches;

  function automatic logic [11:0] scale_clamp(code_t avg, code_t zero, logic [15:0] gain,
                                              logic [11:0] limit);
    logic [27:0] prod;
    logic [19:0] scaled;
    if (avg <= zero) return '0;
    prod = 28'(avg - zero) * 28'(gain);
    scaled = prod[27:8];
    return (scaled > 20'(limit)) ? limit : scaled[11:0];
  endfunction

  function automatic readings_t predict_readings();
    readings_t r;
    code_t avg [NumOutCh];
    logic [27:0] lambda_prod;
    logic [16:0] lambda_sum;
    for (int c = 0; c < NumOutCh; c++) begin
      avg[c] = (c < CHANNEL_COUNT) ? code_t'(channel_sum[c] / RING_DEPTH) : '0;
    end
    lambda_prod = 28'(avg[0]) * 28'(settings.lambda_gain);
    lambda_sum = 17'(settings.lambda_offset) + 17'(lambda_prod[27:12]);
    r.pressure_tenth_kpa = scale_clamp(avg[0], settings.pressure_zero, settings.pressure_gain,
                                       settings.pressure_limit);
    r.throttle_tenth_pct = 10'(scale_clamp(avg[1], settings.throttle_zero,
                                           settings.throttle_gain, 12'(ThrottleFull)));
    r.lambda_q12 = lambda_sum[16] ? 16'hFFFF : lambda_sum[15:0];
    r.intake_temp_code = avg[2];
    r.coolant_temp_code = avg[3];
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings.pressure_zero = PressureZeroReset;
      settings.pressure_gain = PressureGainReset;
      settings.pressure_limit = PressureLimitReset;
      settings.throttle_zero = ThrottleZeroReset;
      settings.throttle_gain = ThrottleGainReset;
      settings.lambda_gain = LambdaGainReset;
      settings.lambda_offset = LambdaOffsetReset;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        channel_sum[c] = '0;
        write_pos[c] = '0;
        for (int e = 0; e < RING_DEPTH; e++) ring_model[c][e] = '0;
      end
      expected_readings.delete();
      mismatches = 0;
      outstanding_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          $error("result with no request waiting: pressure %0d throttle %0d lambda %0d",
                 pressure_tenth_kpa_i, throttle_tenth_pct_i, lambda_q12_i);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          compare_field("pressure_tenth_kpa", 16'(want.pressure_tenth_kpa),
                        16'(pressure_tenth_kpa_i));
          compare_field("throttle_tenth_pct", 16'(want.throttle_tenth_pct),
                        16'(throttle_tenth_pct_i));
          compare_field("lambda_q12", want.lambda_q12, lambda_q12_i);
          compare_field("intake_temp_code", 16'(want.intake_temp_code),
                        16'(intake_temp_code_i));
          compare_field("coolant_temp_code", 16'(want.coolant_temp_code),
                        16'(coolant_temp_code_i));
        end
      end
      if (cfg_write_en_i) begin
        case (cfg_index_i)
          RegPressureZero:  settings.pressure_zero = cfg_data_i[CodeW-1:0];
          RegPressureGain:  settings.pressure_gain = cfg_data_i;
          RegPressureLimit: settings.pressure_limit = cfg_data_i[CodeW-1:0];
          RegThrottleZero:  settings.throttle_zero = cfg_data_i[CodeW-1:0];
          RegThrottleGain:  settings.throttle_gain = cfg_data_i;
          RegLambdaGain:    settings.lambda_gain = cfg_data_i;
          RegLambdaOffset:  settings.lambda_offset = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (op_i == OpRead) begin
          expected_readings.push_back(predict_readings());
        end else if (channel_i < CHANNEL_COUNT) begin
          channel_sum[channel_i] = channel_sum[channel_i]
                                   - 20'(ring_model[channel_i][write_pos[channel_i]])
                                   + 20'(sample_code_i);
          ring_model[channel_i][write_pos[channel_i]] = sample_code_i;
          write_pos[channel_i] = write_pos[channel_i] + 1'b1;
        end
      end
      outstanding_o <= expected_readings.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/sensor_channel_average_scale_core_test.sv -----
// testbench top: drives sample and read requests and register writes, gives the verdict
`timescale 1ns / 1ps
module sensor_channel_average_scale_core_test;
  import scas_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam int unsigned PhaseItems = 320;
  localparam int unsigned NumPhases = 5;

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                req_op = OpSample;
  logic [1:0]          req_channel = '0;
  logic [11:0]         req_code = '0;
  logic                out_stall = 1'b0;
  logic                cfg_write_en = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic        in_stall;
  logic        out_valid;
  logic [11:0] pressure_tenth_kpa;
  logic [9:0]  throttle_tenth_pct;
  logic [15:0] lambda_q12;
  logic [11:0] intake_temp_code;
  logic [11:0] coolant_temp_code;
  int unsigned outstanding;
  int unsigned fail_count;

  int unsigned tx_idle_pct = 16;
  int unsigned rx_idle_pct = 68;

  sensor_channel_average_scale_core u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .op_i                 (req_op),
    .channel_i            (req_channel),
    .sample_code_i        (req_code),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .pressure_tenth_kpa_o (pressure_tenth_kpa),
    .throttle_tenth_pct_o (throttle_tenth_pct),
    .lambda_q12_o         (lambda_q12),
    .intake_temp_code_o   (intake_temp_code),
    .coolant_temp_code_o  (coolant_temp_code),
    .cfg_write_en_i       (cfg_write_en),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data)
  );

  scas_readings_checker u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_stall_i           (in_stall),
    .op_i                 (req_op),
    .channel_i            (req_channel),
    .sample_code_i        (req_code),
    .out_valid_i          (out_valid),
    .out_stall_i          (out_stall),
    .pressure_tenth_kpa_i (pressure_tenth_kpa),
    .throttle_tenth_pct_i (throttle_tenth_pct),
    .lambda_q12_i         (lambda_q12),
    .intake_temp_code_i   (intake_temp_code),
    .coolant_temp_code_i  (coolant_temp_code),
    .cfg_write_en_i       (cfg_write_en),
    .cfg_index_i          (cfg_index),
    .cfg_data_i           (cfg_data),
    .outstanding_o        (outstanding),
    .fail_count_o         (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic send_request(input logic op, input logic [1:0] channel,
                              input logic [11:0] code);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_op <= op;
    req_channel <= channel;
    req_code <= code;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [11:0] pick_level();
    case ($urandom_range(2))
      0: return 12'h000;
      1: return 12'hFFF;
      default: return $urandom_range(4095);
    endcase
  endfunction

  initial begin
    logic [15:0] setting [7];
    logic [11:0] level [4];
    logic [1:0]  ch;
    logic [11:0] code;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset readings, ignored fields on a read, full-scale and zero codes
    send_request(OpRead, 2'd3, 12'hFFF);
    for (int c = 0; c < 4; c++) send_request(OpSample, c[1:0], 12'hFFF);
    send_request(OpRead, 2'd0, 12'h000);
    send_request(OpSample, 2'd0, 12'h000);
    send_request(OpSample, 2'd1, 12'hAAA);
    send_request(OpSample, 2'd2, 12'h555);
    send_request(OpSample, 2'd3, 12'h001);
    send_request(OpRead, 2'd1, 12'h555);
    send_request(OpRead, 2'd2, 12'hAAA);
    send_request(OpSample, 2'd0, 12'h800);
    send_request(OpRead, 2'd0, 12'h800);

    for (int c = 0; c < 4; c++) level[c] = pick_level();

    for (int p = 0; p < NumPhases; p++) begin
      wait_for_results();
      case (p)
        0: begin
          setting[RegPressureZero] = 16'h0000;
          setting[RegPressureGain] = 16'hFFFF;
          setting[RegPressureLimit] = 16'hFFFF;
          setting[RegThrottleZero] = 16'h0000;
          setting[RegThrottleGain] = 16'hFFFF;
          setting[RegLambdaGain] = 16'hFFFF;
          setting[RegLambdaOffset] = 16'hFFFF;
        end
        2: begin
          for (int r = 0; r < 7; r++) setting[r] = $urandom_range(65535);
        end
        3: begin
          setting[RegPressureZero] = 16'h0FFF;
          setting[RegPressureGain] = 16'h0000;
          setting[RegPressureLimit] = 16'h0000;
          setting[RegThrottleZero] = 16'h0FFF;
          setting[RegThrottleGain] = 16'h0000;
          setting[RegLambdaGain] = 16'h0000;
          setting[RegLambdaOffset] = 16'h0000;
        end
        default: begin
          setting[RegPressureZero] = $urandom_range(1500);
          setting[RegPressureGain] = $urandom_range(1024, 64);
          setting[RegPressureLimit] = $urandom_range(4095);
          setting[RegThrottleZero] = $urandom_range(1500);
          setting[RegThrottleGain] = $urandom_range(300, 20);
          setting[RegLambdaGain] = $urandom_range(65535);
          setting[RegLambdaOffset] = $urandom_range(65535);
        end
      endcase
      for (int r = 0; r < 7; r++) begin
        cfg_write_en <= 1'b1;
        cfg_index <= r[CfgIdxW-1:0];
        cfg_data <= setting[r];
        @(posedge clk_i);
      end
      // index past the last register must not disturb anything
      cfg_index <= RegUnused;
      cfg_data <= $urandom_range(65535);
      @(posedge clk_i);
      cfg_write_en <= 1'b0;

      if (p < 2) begin
        tx_idle_pct = 16;
        rx_idle_pct = 68;
      end else if (p < 4) begin
        tx_idle_pct = 68;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(99) < 22) begin
          send_request(OpRead, $urandom_range(3), $urandom_range(4095));
        end else begin
          ch = $urandom_range(3);
          if ($urandom_range(59) == 0) level[ch] = pick_level();
          if ($urandom_range(99) < 85) code = level[ch];
          else code = $urandom_range(4095);
          send_request(OpSample, ch, code);
        end
      end
    end

    wait_for_results();
    repeat (12) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/scas_pkg.sv
src/scas_ring.sv
src/scas_accum.sv
src/scas_scale.sv
src/sensor_channel_average_scale_core.sv
tb/scas_readings_checker.sv
tb/sensor_channel_average_scale_core_test.sv
